@@ hw/rtl/pat_pkg.sv @@
// Package for the positional array table: request, status and cell opcodes,
// controller states and the control bundle broadcast to the entry cells.
// No dependencies.
package pat_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 8;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_SEARCH = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_UPDATE = 3'd4,
        REQ_READ   = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_INSERT,
        CO_DELETE,
        CO_WRITE,
        CO_LOAD_SEARCH,
        CO_LOAD_READ,
        CO_PASS
    } cell_op_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_SCAN
    } fsm_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [VAL_W-1:0]  value;
    } cell_ctl_t;

endpackage

@@ hw/rtl/pat_cell.sv @@
// One entry cell of the positional array table chain.
// Holds one entry and one result token; besides the broadcast control, talks only to its two neighbors.
// Depends on pat_pkg.
module pat_cell
    import pat_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int IDX_W  = 7,
    parameter int CNT_W  = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctl_t                ctl,
    input  logic [IDX_W-1:0]         idx,
    input  logic [CNT_W-1:0]         cnt,
    input  logic signed [VAL_W-1:0]  left_entry,
    input  logic signed [VAL_W-1:0]  right_entry,
    input  logic                     right_tok_vld,
    input  logic [VAL_W-1:0]         right_tok,
    output logic signed [VAL_W-1:0]  entry,
    output logic                     tok_vld,
    output logic [VAL_W-1:0]         tok
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
    localparam logic [VAL_W-1:0] MY_POS = VAL_W'(IDX + 1);

    logic signed [VAL_W-1:0] entry_reg;
    logic                    tok_vld_reg;
    logic [VAL_W-1:0]        tok_reg;

    // Entry storage: shifts toward the top on insert, toward cell 0 on delete.
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            CO_INSERT:
            begin
                if (MY_IDX > idx)
                    entry_reg <= left_entry;
                else if (MY_IDX == idx)
                    entry_reg <= ctl.value;
            end
            CO_DELETE:
            begin
                if (MY_IDX >= idx)
                    entry_reg <= right_entry;
            end
            CO_WRITE:
            begin
                if (MY_IDX == idx)
                    entry_reg <= ctl.value;
            end
            default:
            begin
                entry_reg <= entry_reg;
            end
        endcase
    end

    // Result token: a valid token moves one cell toward cell 0 per pass
    // unless this cell already holds one, so the lowest valid cell wins.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            case (ctl.op)
                CO_LOAD_SEARCH: tok_vld_reg <= (MY_CNT < cnt) && (entry_reg == ctl.value);
                CO_LOAD_READ:   tok_vld_reg <= (MY_IDX == idx);
                CO_PASS:
                begin
                    if (!tok_vld_reg)
                        tok_vld_reg <= right_tok_vld;
                end
                default:        tok_vld_reg <= tok_vld_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            CO_LOAD_SEARCH: tok_reg <= MY_POS;
            CO_LOAD_READ:   tok_reg <= entry_reg;
            CO_PASS:
            begin
                if (!tok_vld_reg)
                    tok_reg <= right_tok;
            end
            default:        tok_reg <= tok_reg;
        endcase
    end

    assign entry   = entry_reg;
    assign tok_vld = tok_vld_reg;
    assign tok     = tok_reg;

endmodule

@@ hw/rtl/pat_ctrl.sv @@
// Request controller of the positional array table: range checks, live count,
// cell command sequencing and the result register.
// Depends on pat_pkg.
module pat_ctrl
    import pat_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               in_req,
    input  logic [POS_W-1:0]         in_pos,
    input  logic signed [VAL_W-1:0]  in_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output status_t                  out_status,
    output logic [7:0]               out_found,
    output logic signed [VAL_W-1:0]  out_read,
    output logic [7:0]               out_count,
    output cell_ctl_t                ctl,
    output logic [IDX_W-1:0]         idx,
    output logic [CNT_W-1:0]         cnt,
    input  logic                     tok0_vld,
    input  logic [VAL_W-1:0]         tok0
);

    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    fsm_t                    state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        scan_reg;
    logic                    search_reg;
    logic                    out_vld_reg;
    status_t                 status_reg;
    logic [7:0]              found_reg;
    logic signed [VAL_W-1:0] read_reg;
    logic [7:0]              count_reg;

    logic                    accept;
    logic [CMP_W-1:0]        pos_w;
    logic [CMP_W-1:0]        cnt_w;
    logic [IDX_W-1:0]        pos_m1;
    logic                    full;
    logic                    pos_ok;
    logic                    ins_ok;
    logic                    scan_done;

    cell_op_t                dec_op;
    logic [IDX_W-1:0]        dec_idx;
    status_t                 dec_status;
    logic [CNT_W-1:0]        dec_cnt;
    logic                    dec_scan;
    logic [CNT_W-1:0]        dec_scan_len;

    assign accept    = in_valid && in_ready;
    assign pos_w     = CMP_W'(in_pos);
    assign cnt_w     = CMP_W'(cnt_reg);
    assign pos_m1    = IDX_W'(pos_w - CMP_W'(1));
    assign full      = (cnt_reg == CAP_CNT);
    assign pos_ok    = (in_pos != '0) && (pos_w <= cnt_w);
    assign ins_ok    = (in_pos != '0) && (pos_w <= cnt_w + CMP_W'(1));
    assign scan_done = (state_reg == FSM_SCAN) && (scan_reg == '0);

    // Request decode against the current live count.
    always_comb
    begin
        dec_op       = CO_HOLD;
        dec_idx      = pos_m1;
        dec_status   = ST_OK;
        dec_cnt      = cnt_reg;
        dec_scan     = 1'b0;
        dec_scan_len = '0;
        case (req_t'(in_req))
            REQ_APPEND:
            begin
                if (full)
                    dec_status = ST_FULL;
                else
                begin
                    dec_op  = CO_INSERT;
                    dec_idx = cnt_reg[IDX_W-1:0];
                    dec_cnt = cnt_reg + CNT_W'(1);
                end
            end
            REQ_SEARCH:
            begin
                if (cnt_reg == '0)
                    dec_status = ST_NOTFOUND;
                else
                begin
                    dec_op       = CO_LOAD_SEARCH;
                    dec_scan     = 1'b1;
                    dec_scan_len = cnt_reg - CNT_W'(1);
                end
            end
            REQ_INSERT:
            begin
                if (full)
                    dec_status = ST_FULL;
                else if (!ins_ok)
                    dec_status = ST_RANGE;
                else
                begin
                    dec_op  = CO_INSERT;
                    dec_cnt = cnt_reg + CNT_W'(1);
                end
            end
            REQ_DELETE:
            begin
                if (!pos_ok)
                    dec_status = ST_RANGE;
                else
                begin
                    dec_op  = CO_DELETE;
                    dec_cnt = cnt_reg - CNT_W'(1);
                end
            end
            REQ_UPDATE:
            begin
                if (!pos_ok)
                    dec_status = ST_RANGE;
                else
                    dec_op = CO_WRITE;
            end
            REQ_READ:
            begin
                if (!pos_ok)
                    dec_status = ST_RANGE;
                else
                begin
                    dec_op       = CO_LOAD_READ;
                    dec_scan     = 1'b1;
                    dec_scan_len = CNT_W'(pos_m1);
                end
            end
            default:
            begin
                dec_op = CO_HOLD;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept && dec_scan)
                    state_next = FSM_SCAN;
            end
            FSM_SCAN:
            begin
                if (scan_reg == '0)
                    state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // State outputs: handshake and cell command.
    always_comb
    begin
        in_ready  = 1'b0;
        ctl.op    = CO_HOLD;
        ctl.value = in_value;
        case (state_reg)
            FSM_IDLE:
            begin
                in_ready = !out_vld_reg || out_ready;
                if (accept)
                    ctl.op = dec_op;
            end
            FSM_SCAN:
            begin
                if (scan_reg != '0)
                    ctl.op = CO_PASS;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign idx = dec_idx;
    assign cnt = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FSM_IDLE;
            cnt_reg     <= '0;
            scan_reg    <= '0;
            search_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg    <= dec_cnt;
                scan_reg   <= dec_scan_len;
                search_reg <= (req_t'(in_req) == REQ_SEARCH);
            end
            else if ((state_reg == FSM_SCAN) && (scan_reg != '0))
            begin
                scan_reg <= scan_reg - CNT_W'(1);
            end

            if ((accept && !dec_scan) || scan_done)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept && !dec_scan)
        begin
            status_reg <= dec_status;
            found_reg  <= '0;
            read_reg   <= '0;
            count_reg  <= 8'(dec_cnt);
        end
        else if (scan_done)
        begin
            status_reg <= (search_reg && !tok0_vld) ? ST_NOTFOUND : ST_OK;
            found_reg  <= (search_reg && tok0_vld) ? tok0[7:0] : 8'd0;
            read_reg   <= search_reg ? '0 : $signed(tok0);
            count_reg  <= 8'(cnt_reg);
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_status = status_reg;
    assign out_found  = found_reg;
    assign out_read   = read_reg;
    assign out_count  = count_reg;

endmodule

@@ hw/rtl/positional_array_table.sv @@
// Positional array table: a packed list of up to CAPACITY signed 32-bit
// entries with a live count, built as a chain of entry cells. Each request item
// on the slave stream appends, searches for the first entry equal to a key,
// inserts or deletes at a 1-based position (later entries shift by one cell),
// overwrites, or reads, and yields exactly one result item on the master
// stream. Append, insert, delete, update and rejected requests finish at the
// accepting edge: every cell takes its new entry from itself or a neighbor then.
// Search and read build a result token in the matching cell and move it one
// cell per cycle toward cell 0, holding the block until a token from the top
// live cell or the read position has reached it; the next item is taken once
// the result register is free or being emptied. A full list answers with
// status 1, a bad position with status 2, a failed search with status 3, and
// the list is then left unchanged. Request kinds 6 and 7 answer status 0 with
// no change. Entry storage has no reset; only live entries are ever visible.
// Depends on pat_pkg, pat_ctrl and pat_cell.
module positional_array_table
    import pat_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[7:0], value[39:8]
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // found_position[7:0], read_value[39:8],
                                        // entry_count[47:40]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_ctl_t               ctl;
    logic [IDX_W-1:0]        idx;
    logic [CNT_W-1:0]        cnt;
    status_t                 status;
    logic [7:0]              found;
    logic signed [VAL_W-1:0] read_value;
    logic [7:0]              count;

    logic signed [VAL_W-1:0] entry_w   [CAPACITY];
    logic                    tok_vld_w [CAPACITY];
    logic [VAL_W-1:0]        tok_w     [CAPACITY];

    pat_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_req     (s_axis_tuser),
        .in_pos     (s_axis_tdata[7:0]),
        .in_value   ($signed(s_axis_tdata[39:8])),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (status),
        .out_found  (found),
        .out_read   (read_value),
        .out_count  (count),
        .ctl        (ctl),
        .idx        (idx),
        .cnt        (cnt),
        .tok0_vld   (tok_vld_w[0]),
        .tok0       (tok_w[0])
    );

    // The cell row. The end cells loop their missing neighbor back to
    // themselves; the top cell feeds an empty token into the chain.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_entry;
        logic signed [VAL_W-1:0] right_entry;
        logic                    right_tok_vld;
        logic [VAL_W-1:0]        right_tok;

        if (i == 0)
        begin : g_first
            assign left_entry = entry_w[i];
        end
        else
        begin : g_inner_left
            assign left_entry = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry   = entry_w[i];
            assign right_tok_vld = 1'b0;
            assign right_tok     = '0;
        end
        else
        begin : g_inner_right
            assign right_entry   = entry_w[i+1];
            assign right_tok_vld = tok_vld_w[i+1];
            assign right_tok     = tok_w[i+1];
        end

        pat_cell #(
            .IDX   (i),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .idx           (idx),
            .cnt           (cnt),
            .left_entry    (left_entry),
            .right_entry   (right_entry),
            .right_tok_vld (right_tok_vld),
            .right_tok     (right_tok),
            .entry         (entry_w[i]),
            .tok_vld       (tok_vld_w[i]),
            .tok           (tok_w[i])
        );
    end

    assign m_axis_tdata = {count, read_value, found};
    assign m_axis_tuser = status;

endmodule

@@ hw/rtl/pat_chk.sv @@
// Port-level checker for the positional array table, bound to the top level.
// Depends on pat_pkg and positional_array_table.
module pat_chk
    import pat_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    localparam logic [7:0] CAP_BYTE = 8'(CAPACITY);

    // Once reset has been applied at an edge, no result item is offered at the next edge.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result offered during reset");

    // A stalled result item holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A full-list answer reports the list at capacity.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> m_axis_tdata[47:40] == CAP_BYTE)
        else $error("full status with count below capacity");

    // A failed search reports neither a position nor a value.
    a_notfound_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NOTFOUND) |->
            (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[39:8] == 32'd0))
        else $error("not-found result carries data");

    // A found position only comes with a successful search, never with a read value.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[7:0] != 8'd0) |->
            (m_axis_tuser == ST_OK) && (m_axis_tdata[39:8] == 32'd0))
        else $error("found position with bad status or read data");

endmodule

bind positional_array_table pat_chk #(
    .CAPACITY (CAPACITY)
) u_pat_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
